// ===== hdl/gpio_port_with_edge_interrupts_unit_defines.svh =====
// Assertion macros shared by the GPIO port with edge interrupts RTL.
`ifndef GPIO_PORT_WITH_EDGE_INTERRUPTS_UNIT_DEFINES_SVH
`define GPIO_PORT_WITH_EDGE_INTERRUPTS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, off while reset is high.
`define GPE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");

// Clocked check that also holds during reset.
`define GPE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`else

`define GPE_ASSERT(lbl, clk, rst, prop)
`define GPE_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hdl/gpe_pkg.sv =====
// Package: types, register offsets and codes of the GPIO port with edge interrupts.
`default_nettype none

package gpe_pkg;

  localparam int unsigned PINS        = 16;
  localparam int unsigned SEL_W       = 8;
  localparam int unsigned PORT_INDEX_DEF = 0;

  typedef logic [1:0]  cmd_t;
  typedef logic [7:0]  offset_t;
  typedef logic [31:0] word_t;
  typedef logic [15:0] pins_t;

  // commands
  localparam cmd_t CMD_READ  = 2'd0;
  localparam cmd_t CMD_WRITE = 2'd1;
  localparam cmd_t CMD_TICK  = 2'd2;

  // register windows
  localparam logic UNIT_GPIO = 1'b0;
  localparam logic UNIT_EXTI = 1'b1;

  // pin mode field codes
  localparam logic [1:0] MODE_OUT = 2'd1;
  localparam logic [1:0] MODE_ALT = 2'd2;

  // GPIO window
  localparam offset_t GPIO_MODE   = 8'h00;
  localparam offset_t GPIO_OTYPE  = 8'h04;
  localparam offset_t GPIO_SPEED  = 8'h08;
  localparam offset_t GPIO_PULL   = 8'h0C;
  localparam offset_t GPIO_IN     = 8'h10;
  localparam offset_t GPIO_OUT    = 8'h14;
  localparam offset_t GPIO_SETRST = 8'h18;
  localparam offset_t GPIO_AFLO   = 8'h20;
  localparam offset_t GPIO_AFHI   = 8'h24;

  // edge interrupt window
  localparam offset_t EXTI_RISE_EN = 8'h00;
  localparam offset_t EXTI_FALL_EN = 8'h04;
  localparam offset_t EXTI_RISE_PD = 8'h0C;
  localparam offset_t EXTI_FALL_PD = 8'h10;
  localparam offset_t EXTI_SEL0    = 8'h60;
  localparam offset_t EXTI_SEL1    = 8'h64;
  localparam offset_t EXTI_SEL2    = 8'h68;
  localparam offset_t EXTI_SEL3    = 8'h6C;
  localparam offset_t EXTI_MASK    = 8'h80;

  typedef struct packed {
    cmd_t    cmd;
    logic    unit;
    offset_t offset;
    word_t   wdata;
    pins_t   pin_levels;
  } in_item_t;

  typedef struct packed {
    word_t rdata;
    pins_t pad_out;
    pins_t pad_drive;
    pins_t irq_pending;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hdl/gpe_if.sv =====
// Valid/ready channel interfaces for command items and result items.
`default_nettype none

interface gpe_in_if;
  logic             valid;
  logic             ready;
  gpe_pkg::cmd_t    cmd;
  logic             unit;
  gpe_pkg::offset_t offset;
  gpe_pkg::word_t   wdata;
  gpe_pkg::pins_t   pin_levels;

  modport source(output valid, cmd, unit, offset, wdata, pin_levels, input ready);
  modport sink(input valid, cmd, unit, offset, wdata, pin_levels, output ready);
endinterface

interface gpe_out_if;
  logic           valid;
  logic           ready;
  gpe_pkg::word_t rdata;
  gpe_pkg::pins_t pad_out;
  gpe_pkg::pins_t pad_drive;
  gpe_pkg::pins_t irq_pending;

  modport source(output valid, rdata, pad_out, pad_drive, irq_pending, input ready);
  modport sink(input valid, rdata, pad_out, pad_drive, irq_pending, output ready);
endinterface

`default_nettype wire

// ===== hdl/gpe_regs.sv =====
// Register file, edge detection and result logic of the GPIO port.
`default_nettype none
`include "gpio_port_with_edge_interrupts_unit_defines.svh"

module gpe_regs #(
  parameter int unsigned PORT_INDEX = gpe_pkg::PORT_INDEX_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire gpe_pkg::in_item_t  item,
  output gpe_pkg::out_item_t      res
);

  gpe_pkg::word_t mode_bits, mode_bits_next;
  gpe_pkg::pins_t out_type_bits, out_type_bits_next;
  gpe_pkg::word_t speed_bits, speed_bits_next;
  gpe_pkg::word_t pull_bits, pull_bits_next;
  gpe_pkg::pins_t out_data, out_data_next;
  gpe_pkg::word_t altfn_lo, altfn_lo_next;
  gpe_pkg::word_t altfn_hi, altfn_hi_next;
  gpe_pkg::pins_t in_data, in_data_next;
  gpe_pkg::pins_t rise_enable, rise_enable_next;
  gpe_pkg::pins_t fall_enable, fall_enable_next;
  gpe_pkg::pins_t rise_pending, rise_pending_next;
  gpe_pkg::pins_t fall_pending, fall_pending_next;
  gpe_pkg::pins_t line_mask, line_mask_next;
  logic [3:0][31:0] port_select, port_select_next;

  gpe_pkg::pins_t sel_lines;
  gpe_pkg::pins_t drive;
  gpe_pkg::word_t rdata;
  gpe_pkg::pins_t wlo, whi;

  assign wlo = item.wdata[15:0];
  assign whi = item.wdata[31:16];

  // lines whose port selector names this port
  always_comb begin
    for (int n = 0; n < gpe_pkg::PINS; n++) begin
      sel_lines[n] = (port_select[n / 4][8 * (n % 4) +: gpe_pkg::SEL_W]
                      == gpe_pkg::SEL_W'(PORT_INDEX));
    end
  end

  always_comb begin
    mode_bits_next     = mode_bits;
    out_type_bits_next = out_type_bits;
    speed_bits_next    = speed_bits;
    pull_bits_next     = pull_bits;
    out_data_next      = out_data;
    altfn_lo_next      = altfn_lo;
    altfn_hi_next      = altfn_hi;
    in_data_next       = in_data;
    rise_enable_next   = rise_enable;
    fall_enable_next   = fall_enable;
    rise_pending_next  = rise_pending;
    fall_pending_next  = fall_pending;
    line_mask_next     = line_mask;
    port_select_next   = port_select;
    rdata              = '0;
    case (item.cmd)
      gpe_pkg::CMD_READ: begin
        if (item.unit == gpe_pkg::UNIT_EXTI) begin
          case (item.offset)
            gpe_pkg::EXTI_RISE_EN: rdata = {16'h0, rise_enable};
            gpe_pkg::EXTI_FALL_EN: rdata = {16'h0, fall_enable};
            gpe_pkg::EXTI_RISE_PD: rdata = {16'h0, rise_pending};
            gpe_pkg::EXTI_FALL_PD: rdata = {16'h0, fall_pending};
            gpe_pkg::EXTI_SEL0:    rdata = port_select[0];
            gpe_pkg::EXTI_SEL1:    rdata = port_select[1];
            gpe_pkg::EXTI_SEL2:    rdata = port_select[2];
            gpe_pkg::EXTI_SEL3:    rdata = port_select[3];
            gpe_pkg::EXTI_MASK:    rdata = {16'h0, line_mask};
            default:               rdata = '0;
          endcase
        end else begin
          case (item.offset)
            gpe_pkg::GPIO_MODE:  rdata = mode_bits;
            gpe_pkg::GPIO_OTYPE: rdata = {16'h0, out_type_bits};
            gpe_pkg::GPIO_SPEED: rdata = speed_bits;
            gpe_pkg::GPIO_PULL:  rdata = pull_bits;
            gpe_pkg::GPIO_IN:    rdata = {16'h0, in_data};
            gpe_pkg::GPIO_OUT:   rdata = {16'h0, out_data};
            gpe_pkg::GPIO_AFLO:  rdata = altfn_lo;
            gpe_pkg::GPIO_AFHI:  rdata = altfn_hi;
            default:             rdata = '0;
          endcase
        end
      end
      gpe_pkg::CMD_WRITE: begin
        if (item.unit == gpe_pkg::UNIT_EXTI) begin
          case (item.offset)
            gpe_pkg::EXTI_RISE_EN: rise_enable_next = wlo;
            gpe_pkg::EXTI_FALL_EN: fall_enable_next = wlo;
            gpe_pkg::EXTI_RISE_PD: rise_pending_next = rise_pending & ~wlo;
            gpe_pkg::EXTI_FALL_PD: fall_pending_next = fall_pending & ~wlo;
            gpe_pkg::EXTI_SEL0:    port_select_next[0] = item.wdata;
            gpe_pkg::EXTI_SEL1:    port_select_next[1] = item.wdata;
            gpe_pkg::EXTI_SEL2:    port_select_next[2] = item.wdata;
            gpe_pkg::EXTI_SEL3:    port_select_next[3] = item.wdata;
            gpe_pkg::EXTI_MASK:    line_mask_next = wlo;
            default: ;
          endcase
        end else begin
          case (item.offset)
            gpe_pkg::GPIO_MODE:   mode_bits_next = item.wdata;
            gpe_pkg::GPIO_OTYPE:  out_type_bits_next = wlo;
            gpe_pkg::GPIO_SPEED:  speed_bits_next = item.wdata;
            gpe_pkg::GPIO_PULL:   pull_bits_next = item.wdata;
            gpe_pkg::GPIO_OUT:    out_data_next = wlo;
            // set wins over reset
            gpe_pkg::GPIO_SETRST: out_data_next = (out_data & ~whi) | wlo;
            gpe_pkg::GPIO_AFLO:   altfn_lo_next = item.wdata;
            gpe_pkg::GPIO_AFHI:   altfn_hi_next = item.wdata;
            default: ;
          endcase
        end
      end
      gpe_pkg::CMD_TICK: begin
        rise_pending_next = rise_pending
                          | (~in_data & item.pin_levels & rise_enable & sel_lines);
        fall_pending_next = fall_pending
                          | (in_data & ~item.pin_levels & fall_enable & sel_lines);
        in_data_next      = item.pin_levels;
      end
      default: ;
    endcase
  end

  // drive decode uses the mode after this item
  always_comb begin
    for (int n = 0; n < gpe_pkg::PINS; n++) begin
      drive[n] = (mode_bits_next[2 * n +: 2] == gpe_pkg::MODE_OUT)
              || (mode_bits_next[2 * n +: 2] == gpe_pkg::MODE_ALT);
    end
  end

  assign res.rdata       = rdata;
  assign res.pad_out     = out_data_next;
  assign res.pad_drive   = drive;
  assign res.irq_pending = (rise_pending_next | fall_pending_next) & line_mask_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bits     <= '0;
      out_type_bits <= '0;
      speed_bits    <= '0;
      pull_bits     <= '0;
      out_data      <= '0;
      altfn_lo      <= '0;
      altfn_hi      <= '0;
      in_data       <= '0;
      rise_enable   <= '0;
      fall_enable   <= '0;
      rise_pending  <= '0;
      fall_pending  <= '0;
      line_mask     <= '0;
      port_select   <= '0;
    end else if (go) begin
      mode_bits     <= mode_bits_next;
      out_type_bits <= out_type_bits_next;
      speed_bits    <= speed_bits_next;
      pull_bits     <= pull_bits_next;
      out_data      <= out_data_next;
      altfn_lo      <= altfn_lo_next;
      altfn_hi      <= altfn_hi_next;
      in_data       <= in_data_next;
      rise_enable   <= rise_enable_next;
      fall_enable   <= fall_enable_next;
      rise_pending  <= rise_pending_next;
      fall_pending  <= fall_pending_next;
      line_mask     <= line_mask_next;
      port_select   <= port_select_next;
    end
  end

  // pending bits are only raised by a sample tick
  `GPE_ASSERT(a_rise_only_on_tick, clk, rst,
    !(go && item.cmd == gpe_pkg::CMD_TICK) |=> ((rise_pending & ~$past(rise_pending)) == '0))
  `GPE_ASSERT(a_fall_only_on_tick, clk, rst,
    !(go && item.cmd == gpe_pkg::CMD_TICK) |=> ((fall_pending & ~$past(fall_pending)) == '0))
  // the input sample moves only on a tick
  `GPE_ASSERT(a_in_data_tick, clk, rst,
    !(go && item.cmd == gpe_pkg::CMD_TICK) |=> $stable(in_data))
  // output data moves only on a GPIO-window write
  `GPE_ASSERT(a_out_data_write, clk, rst,
    !(go && item.cmd == gpe_pkg::CMD_WRITE && item.unit == gpe_pkg::UNIT_GPIO)
      |=> $stable(out_data))

endmodule

`default_nettype wire

// ===== hdl/gpe_out_reg.sv =====
// Result register driving the output channel.
`default_nettype none
`include "gpio_port_with_edge_interrupts_unit_defines.svh"

module gpe_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire gpe_pkg::out_item_t res,
  output logic                    load_ok,
  gpe_out_if.source               out_ch
);

  logic               valid;
  gpe_pkg::out_item_t data;

  // free when empty or being drained this cycle
  assign load_ok = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load_ok) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ok) begin
      data <= res;
    end
  end

  assign out_ch.valid       = valid;
  assign out_ch.rdata       = data.rdata;
  assign out_ch.pad_out     = data.pad_out;
  assign out_ch.pad_drive   = data.pad_drive;
  assign out_ch.irq_pending = data.irq_pending;

  // a stalled result is never overwritten
  `GPE_ASSERT(a_hold_on_stall, clk, rst,
    (valid && !out_ch.ready) |=> (valid && $stable(data)))
  `GPE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !valid)

endmodule

`default_nettype wire

// ===== hdl/gpio_port_with_edge_interrupts_unit.sv =====
// Top level: 16-pin GPIO port with a 16-line edge interrupt unit.
// Path: an accepted item passes the input register, then the register file update
//   and the result register, which presents its result item.
// Throughput: one item per cycle while the output channel is not stalled.
// Reset: synchronous, active high; all registers read zero, all pins are inputs,
//   all lines masked, nothing pending, both pipeline stages empty.
`default_nettype none

module gpio_port_with_edge_interrupts_unit #(
  parameter int unsigned PORT_INDEX = gpe_pkg::PORT_INDEX_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  gpe_in_if.sink    in_ch,
  gpe_out_if.source out_ch
);

  // Input register: holds one command item in front of the register file.
  logic               s_valid;
  gpe_pkg::in_item_t  s_item;

  // load_ok: the result register can take a result this cycle.
  logic               load_ok;
  logic               go;
  gpe_pkg::out_item_t res;

  // The input stage advances whenever the result register can take its item,
  // so a new item enters every cycle while results keep draining.
  assign go          = s_valid && load_ok;
  assign in_ch.ready = !s_valid || load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid <= in_ch.valid;
    end
  end

  // Payload needs no reset; it is qualified by s_valid.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s_item.cmd        <= in_ch.cmd;
      s_item.unit       <= in_ch.unit;
      s_item.offset     <= in_ch.offset;
      s_item.wdata      <= in_ch.wdata;
      s_item.pin_levels <= in_ch.pin_levels;
    end
  end

  // Register file, edge detect and output decode; state commits on go.
  gpe_regs #(
    .PORT_INDEX(PORT_INDEX)
  ) u_regs (
    .clk (clk),
    .rst (rst),
    .go  (go),
    .item(s_item),
    .res (res)
  );

  // Result register toward the output channel.
  gpe_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (go),
    .res    (res),
    .load_ok(load_ok),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the GPIO port with edge interrupts: shadow-register predictor.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gpe_pkg::*;

  // Port number this instance answers to in the line selector fields.
  localparam int unsigned THIS_PORT = PORT_INDEX_DEF;

  // Command code with no effect; the block must still report its state.
  localparam cmd_t CMD_NOP = 2'd3;

  // Unmapped holes: the lock register of the GPIO window, a gap in the interrupt window.
  localparam offset_t GPIO_LOCK = 8'h1C;
  localparam offset_t EXTI_HOLE = 8'h08;

  // Offsets random bus accesses pick from, one hole per window included.
  localparam offset_t GPIO_MAP [10] = '{GPIO_MODE, GPIO_OTYPE, GPIO_SPEED, GPIO_PULL,
                                        GPIO_IN, GPIO_OUT, GPIO_SETRST, GPIO_LOCK,
                                        GPIO_AFLO, GPIO_AFHI};
  localparam offset_t EXTI_MAP [10] = '{EXTI_RISE_EN, EXTI_FALL_EN, EXTI_HOLE, EXTI_RISE_PD,
                                        EXTI_FALL_PD, EXTI_SEL0, EXTI_SEL1, EXTI_SEL2,
                                        EXTI_SEL3, EXTI_MASK};

  logic clk = 1'b0;
  logic rst;

  gpe_in_if  in_ch ();
  gpe_out_if out_ch ();

  gpio_port_with_edge_interrupts_unit #(
    .PORT_INDEX(THIS_PORT)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of every register of the port and the interrupt unit.
  // ---------------------------------------------------------------------------
  word_t shadow_mode  = '0;
  pins_t shadow_otype = '0;
  word_t shadow_speed = '0;
  word_t shadow_pull  = '0;
  pins_t shadow_odr   = '0;
  pins_t shadow_idr   = '0;   // also the previous sample for edge detection
  word_t shadow_af [2]  = '{default: '0};
  pins_t shadow_rise_en = '0;
  pins_t shadow_fall_en = '0;
  pins_t shadow_rise_pd = '0;
  pins_t shadow_fall_pd = '0;
  pins_t shadow_mask    = '0;   // 1 = line unmasked
  word_t shadow_sel [4] = '{default: '0};

  // Stimulus backlog, expected results and bookkeeping.
  in_item_t  cmd_backlog [$];
  out_item_t awaited_outputs [$];
  int        issued_count   = 0;
  int        accepted_count = 0;
  int        mismatches     = 0;
  int        idle_pct       = 0;   // sender: chance in 100 of leaving a cycle empty
  int        stall_pct      = 0;   // receiver: chance in 100 of holding ready low
  logic      pressure_start = 1'b0;
  logic      hold_off       = 1'b0;
  pins_t     last_pins      = '0;

  // Applies one command to the shadow registers and returns what the block reports after it.
  function automatic out_item_t next_port_outputs(in_item_t c);
    out_item_t res;
    pins_t     lo;
    pins_t     sel_lines;
    pins_t     rising;
    pins_t     falling;
    res = '0;
    lo  = c.wdata[15:0];
    case (c.cmd)
      CMD_READ: begin
        if (c.unit == UNIT_EXTI) begin
          case (c.offset)
            EXTI_RISE_EN: res.rdata = {16'h0, shadow_rise_en};
            EXTI_FALL_EN: res.rdata = {16'h0, shadow_fall_en};
            EXTI_RISE_PD: res.rdata = {16'h0, shadow_rise_pd};
            EXTI_FALL_PD: res.rdata = {16'h0, shadow_fall_pd};
            EXTI_SEL0:    res.rdata = shadow_sel[0];
            EXTI_SEL1:    res.rdata = shadow_sel[1];
            EXTI_SEL2:    res.rdata = shadow_sel[2];
            EXTI_SEL3:    res.rdata = shadow_sel[3];
            EXTI_MASK:    res.rdata = {16'h0, shadow_mask};
            default:      res.rdata = '0;
          endcase
        end else begin
          // set/reset is write only and falls to the default
          case (c.offset)
            GPIO_MODE:  res.rdata = shadow_mode;
            GPIO_OTYPE: res.rdata = {16'h0, shadow_otype};
            GPIO_SPEED: res.rdata = shadow_speed;
            GPIO_PULL:  res.rdata = shadow_pull;
            GPIO_IN:    res.rdata = {16'h0, shadow_idr};
            GPIO_OUT:   res.rdata = {16'h0, shadow_odr};
            GPIO_AFLO:  res.rdata = shadow_af[0];
            GPIO_AFHI:  res.rdata = shadow_af[1];
            default:    res.rdata = '0;
          endcase
        end
      end
      CMD_WRITE: begin
        if (c.unit == UNIT_EXTI) begin
          case (c.offset)
            EXTI_RISE_EN: shadow_rise_en = lo;
            EXTI_FALL_EN: shadow_fall_en = lo;
            EXTI_RISE_PD: shadow_rise_pd &= ~lo;   // write ones to clear
            EXTI_FALL_PD: shadow_fall_pd &= ~lo;
            EXTI_SEL0:    shadow_sel[0] = c.wdata;
            EXTI_SEL1:    shadow_sel[1] = c.wdata;
            EXTI_SEL2:    shadow_sel[2] = c.wdata;
            EXTI_SEL3:    shadow_sel[3] = c.wdata;
            EXTI_MASK:    shadow_mask = lo;
            default:      ;
          endcase
        end else begin
          case (c.offset)
            GPIO_MODE:   shadow_mode = c.wdata;
            GPIO_OTYPE:  shadow_otype = lo;
            GPIO_SPEED:  shadow_speed = c.wdata;
            GPIO_PULL:   shadow_pull = c.wdata;
            GPIO_OUT:    shadow_odr = lo;
            // clear with the high half, then set with the low half: set wins
            GPIO_SETRST: shadow_odr = (shadow_odr & ~c.wdata[31:16]) | lo;
            GPIO_AFLO:   shadow_af[0] = c.wdata;
            GPIO_AFHI:   shadow_af[1] = c.wdata;
            default:     ;
          endcase
        end
      end
      CMD_TICK: begin
        for (int n = 0; n < PINS; n++) begin
          sel_lines[n] = (shadow_sel[n / 4][8 * (n % 4) +: 8] == THIS_PORT);
        end
        rising  = ~shadow_idr & c.pin_levels;
        falling = shadow_idr & ~c.pin_levels;
        shadow_rise_pd |= rising & shadow_rise_en & sel_lines;
        shadow_fall_pd |= falling & shadow_fall_en & sel_lines;
        shadow_idr = c.pin_levels;
      end
      default: ;
    endcase
    res.pad_out = shadow_odr;
    for (int n = 0; n < PINS; n++) begin
      res.pad_drive[n] = (shadow_mode[2 * n +: 2] == MODE_OUT) ||
                         (shadow_mode[2 * n +: 2] == MODE_ALT);
    end
    res.irq_pending = (shadow_rise_pd | shadow_fall_pd) & shadow_mask;
    return res;
  endfunction

  task automatic push_cmd(cmd_t cmd, logic unit, offset_t offset, word_t wdata, pins_t pins);
    in_item_t c;
    c = '{cmd: cmd, unit: unit, offset: offset, wdata: wdata, pin_levels: pins};
    cmd_backlog.push_back(c);
    issued_count++;
  endtask

  // Random traffic: mostly well-formed register accesses and pin samples, with
  // selector write data kept sparse so most lines stay routed to this port.
  task automatic push_random_commands(int count);
    int      kind;
    cmd_t    cmd;
    logic    unit;
    offset_t offset;
    word_t   wdata;
    pins_t   pins;
    for (int i = 0; i < count; i++) begin
      kind   = $urandom_range(99);
      unit   = 1'($urandom_range(1));
      offset = offset_t'($urandom);
      wdata  = $urandom;
      pins   = pins_t'($urandom);
      if (kind < 35) begin
        cmd = CMD_TICK;
        // toggling a few pins gives clean single edges
        if ($urandom_range(1))
          pins = last_pins ^ pins_t'($urandom & $urandom & $urandom);
        last_pins = pins;
      end else if (kind < 90) begin
        cmd    = (kind < 55) ? CMD_READ : CMD_WRITE;
        offset = (unit == UNIT_EXTI) ? EXTI_MAP[$urandom_range(9)] : GPIO_MAP[$urandom_range(9)];
        if (unit == UNIT_EXTI && offset inside {EXTI_SEL0, EXTI_SEL1, EXTI_SEL2, EXTI_SEL3} &&
            $urandom_range(3) != 0)
          wdata = $urandom & $urandom & $urandom & $urandom;
      end else if (kind < 95) begin
        cmd = CMD_NOP;
      end else begin
        cmd = cmd_t'($urandom_range(3));   // noise: anything, any offset
        if (cmd == CMD_TICK)
          last_pins = pins;
      end
      push_cmd(cmd, unit, offset, wdata, pins);
    end
  endtask

  task automatic wait_drained();
    while (accepted_count != issued_count)
      @(posedge clk);
  endtask

  task automatic run_phase(int sender_idle, int receiver_stall, int count);
    idle_pct  <= sender_idle;
    stall_pct <= receiver_stall;
    push_random_commands(count);
    wait_drained();
  endtask

  task automatic check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next backlog item once the current one is taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    in_item_t c;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
        c = cmd_backlog.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= c.cmd;
        in_ch.unit       <= c.unit;
        in_ch.offset     <= c.offset;
        in_ch.wdata      <= c.wdata;
        in_ch.pin_levels <= c.pin_levels;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus the long hold-off of the pressure phase.
  always @(posedge clk) begin
    if (rst)
      out_ch.ready <= 1'b0;
    else
      out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // Long hold-off, counted here so the sender keeps offering meanwhile and the
  // block has to back up into its input.
  initial begin : receiver_holdoff
    wait (pressure_start);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on every accepted command, checks every accepted result.
  // Prediction goes first so ordering inside one edge never matters.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    in_item_t  c;
    out_item_t want;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        c = '{cmd: in_ch.cmd, unit: in_ch.unit, offset: in_ch.offset, wdata: in_ch.wdata,
              pin_levels: in_ch.pin_levels};
        awaited_outputs.push_back(next_port_outputs(c));
        accepted_count++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_outputs.size() == 0) begin
          $error("result item with no expectation waiting: rdata 0x%0h", out_ch.rdata);
          mismatches++;
        end else begin
          want = awaited_outputs.pop_front();
          check_field("rdata", want.rdata, out_ch.rdata);
          check_field("pad_out", word_t'(want.pad_out), word_t'(out_ch.pad_out));
          check_field("pad_drive", word_t'(want.pad_drive), word_t'(out_ch.pad_drive));
          check_field("irq_pending", word_t'(want.irq_pending), word_t'(out_ch.irq_pending));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed items, random phases, pressure, drain.
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values, field extremes, write/read-only corners.
    push_cmd(CMD_READ,  UNIT_GPIO, GPIO_MODE,   '0, '0);
    push_cmd(CMD_WRITE, UNIT_GPIO, GPIO_MODE,   32'hE4E4_E4E4, '0);  // all four mode codes
    push_cmd(CMD_WRITE, UNIT_GPIO, GPIO_OTYPE,  32'hFFFF_FFFF, '0);  // upper half dropped
    push_cmd(CMD_WRITE, UNIT_GPIO, GPIO_SPEED,  32'hFFFF_FFFF, '0);
    push_cmd(CMD_WRITE, UNIT_GPIO, GPIO_PULL,   32'hA5A5_5A5A, '0);
    push_cmd(CMD_WRITE, UNIT_GPIO, GPIO_OUT,    32'hFFFF_0000, '0);
    push_cmd(CMD_WRITE, UNIT_GPIO, GPIO_SETRST, 32'hFFFF_00FF, '0);  // set and clear: set wins
    push_cmd(CMD_READ,  UNIT_GPIO, GPIO_SETRST, '0, '0);             // write only, reads 0
    push_cmd(CMD_WRITE, UNIT_GPIO, GPIO_IN,     32'hFFFF_FFFF, '0);  // read only, ignored
    push_cmd(CMD_WRITE, UNIT_GPIO, GPIO_AFHI,   32'hFEDC_BA98, '0);
    push_cmd(CMD_READ,  UNIT_GPIO, GPIO_AFHI,   '0, '0);
    push_cmd(CMD_WRITE, UNIT_GPIO, GPIO_LOCK,   32'hFFFF_FFFF, '0);  // lock left out
    push_cmd(CMD_READ,  UNIT_GPIO, 8'hFF,       '0, 16'hFFFF);       // misaligned
    // Edge interrupts: enable everything, then rise and fall on all pins.
    push_cmd(CMD_WRITE, UNIT_EXTI, EXTI_RISE_EN, 32'hFFFF_FFFF, '0);
    push_cmd(CMD_WRITE, UNIT_EXTI, EXTI_FALL_EN, 32'hFFFF_FFFF, '0);
    push_cmd(CMD_WRITE, UNIT_EXTI, EXTI_MASK,    32'hFFFF_FFFF, '0);
    push_cmd(CMD_TICK,  UNIT_EXTI, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);  // unit/offset ignored
    push_cmd(CMD_TICK,  UNIT_GPIO, '0, '0, 16'h0000);
    push_cmd(CMD_READ,  UNIT_EXTI, EXTI_FALL_PD, '0, '0);
    push_cmd(CMD_WRITE, UNIT_EXTI, EXTI_RISE_PD, 32'h0000_FFFF, '0);
    push_cmd(CMD_WRITE, UNIT_EXTI, EXTI_FALL_PD, 32'hFFFF_0F0F, '0);
    // Route line 1 to another port: only line 0 may fire.
    push_cmd(CMD_WRITE, UNIT_EXTI, EXTI_SEL0,    32'h0000_FF00, '0);
    push_cmd(CMD_TICK,  UNIT_GPIO, '0, '0, 16'h0003);
    push_cmd(CMD_NOP,   UNIT_EXTI, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF);
    push_cmd(CMD_READ,  UNIT_EXTI, EXTI_SEL0,    '0, '0);
    last_pins = 16'h0003;
    wait_drained();

    // Random traffic under each idling pattern.
    run_phase(0, 0, 450);
    run_phase(70, 0, 450);
    run_phase(0, 70, 450);
    run_phase(23, 23, 450);

    // Pressure: receiver holds off while the sender streams back to back.
    idle_pct       <= 0;
    stall_pct      <= 0;
    pressure_start <= 1'b1;
    push_random_commands(200);
    wait_drained();

    while (awaited_outputs.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);   // catch any stray result left in the input or result register

    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/gpe_pkg.sv
hdl/gpe_if.sv
hdl/gpe_regs.sv
hdl/gpe_out_reg.sv
hdl/gpio_port_with_edge_interrupts_unit.sv
verif/testbench.sv
